// ===== rtl/ptb_pkg.sv =====
// shared constants and control/status types of the periodic timer bank
`timescale 1ns / 1ps

package ptb_pkg;

	localparam int NUM_TIMERS = 4;
	localparam int SLOT_W     = $clog2(NUM_TIMERS);
	localparam int TIME_W     = 32;
	localparam int PRIO_W     = 3;
	localparam int CFG_IDX_W  = 3;
	localparam int IN_DATA_W  = 72;
	localparam int OUT_DATA_W = 8;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_PERIOD_0 = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PERIOD_1 = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PERIOD_2 = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_PERIOD_3 = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_PRIO_MAP = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_RUN_MASK = 3'd5;

	// input commands
	localparam logic CMD_TICK    = 1'b0;
	localparam logic CMD_RESTART = 1'b1;

	// reset values of the configuration registers
	localparam logic [TIME_W-1:0]            PERIOD_RST   = 32'd1000;
	localparam logic [NUM_TIMERS*PRIO_W-1:0] PRIO_MAP_RST = 12'd1170;
	localparam logic [NUM_TIMERS-1:0]        RUN_MASK_RST = 4'hF;

	typedef struct packed {
		logic load;       // input transaction taken
		logic diff;       // elapsed time of current slot
		logic upd;        // update current slot
		logic cnt_inc;    // next slot
		logic scan_init;  // restart ordering scan
		logic scan_step;  // compare current slot against best
		logic emit;       // load output register
	} ptb_cmd_t;

	typedef struct packed {
		logic cnt_last;   // slot counter on final slot
		logic out_free;   // output register can take a result
		logic emit_last;  // result about to go out is the final one
	} ptb_sts_t;

endpackage

// ===== rtl/periodic_timer_bank_top.sv =====
// top level of the periodic timer bank
`timescale 1ns / 1ps

// Bank of four periodic timers with 32-bit wrapping millisecond arithmetic.
// Each input transaction is either a tick (tuser 0) carrying the current
// time, or a restart (tuser 1) that loads a new period into one slot and
// sets its start to now; a restart produces no result. The first tick loads
// every slot with its configured period and fires them all. Later ticks fire
// each running slot whose elapsed time reached its period. The fired slots
// leave one result transaction each, ordered by higher priority, then shorter
// configured period, then higher slot index, with tlast on the final one; a
// tick that fires nothing gives a single result with tuser (fired) low.
// Sequence: a restart is taken in idle and the bank stays idle. A tick is
// taken in idle, then walks the slots one at a time through one shared
// subtract/compare unit with a diff step and an update step per slot, and
// then picks each result with a scan over all four slots followed by an
// output step that waits while the output register is full. The input side
// is ready only between ticks; the output register lets the last result of
// one tick wait while the next transaction is taken. Configuration writes
// are always taken and must only be made while the bank is idle.
module periodic_timer_bank_top (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// configuration write channel
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [ptb_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [ptb_pkg::TIME_W-1:0]            cfg_data,
	// input stream
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	input  logic [ptb_pkg::IN_DATA_W-1:0]         s_tdata,  // now_ms, slot, new_period, zero fill
	input  logic                                  s_tuser,  // command
	// result stream
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	output logic [ptb_pkg::OUT_DATA_W-1:0]        m_tdata,  // timer_index, zero fill
	output logic                                  m_tuser,  // fired
	output logic                                  m_tlast   // last
);

	ptb_pkg::ptb_cmd_t            cmd;
	ptb_pkg::ptb_sts_t            sts;
	logic [ptb_pkg::SLOT_W-1:0]   out_index;

	// registers are plain flops, a write always completes at once
	assign cfg_ready = 1'b1;

	ptb_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_command (s_tuser),
		.in_ready   (s_tready),
		.sts        (sts),
		.cmd        (cmd)
	);

	ptb_datapath u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_data    (s_tdata),
		.in_command (s_tuser),
		.out_index  (out_index),
		.out_fired  (m_tuser),
		.out_last   (m_tlast),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.cmd        (cmd),
		.sts        (sts)
	);

	// slot index in the low bits, rest of the byte zero
	assign m_tdata = {{(ptb_pkg::OUT_DATA_W - ptb_pkg::SLOT_W){1'b0}}, out_index};

endmodule

// ===== rtl/ptb_ctrl.sv =====
// controller state machine of the periodic timer bank
`timescale 1ns / 1ps

module ptb_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_command,
	output logic               in_ready,
	input  ptb_pkg::ptb_sts_t  sts,
	output ptb_pkg::ptb_cmd_t  cmd
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_DIFF = 3'd1;
	localparam logic [2:0] ST_UPD  = 3'd2;
	localparam logic [2:0] ST_SCAN = 3'd3;
	localparam logic [2:0] ST_EMIT = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					if (in_command == ptb_pkg::CMD_TICK) begin
						state_d = ST_DIFF;
					end
				end
			end
			ST_DIFF: begin
				cmd.diff = 1'b1;
				state_d  = ST_UPD;
			end
			ST_UPD: begin
				cmd.upd = 1'b1;
				if (sts.cnt_last) begin
					cmd.scan_init = 1'b1;
					state_d       = ST_SCAN;
				end else begin
					cmd.cnt_inc = 1'b1;
					state_d     = ST_DIFF;
				end
			end
			ST_SCAN: begin
				cmd.scan_step = 1'b1;
				cmd.cnt_inc   = 1'b1;
				if (sts.cnt_last) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					if (sts.emit_last) begin
						state_d = ST_IDLE;
					end else begin
						cmd.scan_init = 1'b1;
						state_d       = ST_SCAN;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// a result is only produced once the output side can take it
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> sts.out_free) else $error("emit into busy output register");

	// the walk over slots never skips from update straight to output
	a_upd_to_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_UPD) && sts.cnt_last |=> (state_q == ST_SCAN))
		else $error("update walk did not end in scan");

	// a restart never leaves idle
	a_restart_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load && (in_command == ptb_pkg::CMD_RESTART) |=> (state_q == ST_IDLE))
		else $error("restart left idle");

endmodule

// ===== rtl/ptb_datapath.sv =====
// timer state, configuration registers, ordering scan and output register
`timescale 1ns / 1ps

module ptb_datapath (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_valid,
	input  logic [ptb_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [ptb_pkg::TIME_W-1:0]           cfg_data,
	input  logic [ptb_pkg::IN_DATA_W-1:0]        in_data,
	input  logic                                 in_command,
	output logic [ptb_pkg::SLOT_W-1:0]           out_index,
	output logic                                 out_fired,
	output logic                                 out_last,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	input  ptb_pkg::ptb_cmd_t                    cmd,
	output ptb_pkg::ptb_sts_t                    sts
);

	localparam int NT = ptb_pkg::NUM_TIMERS;
	localparam int SW = ptb_pkg::SLOT_W;
	localparam int TW = ptb_pkg::TIME_W;
	localparam int PW = ptb_pkg::PRIO_W;

	// configuration
	logic [TW-1:0]      period_cfg_q [NT];
	logic [NT*PW-1:0]   prio_map_q;
	logic [NT-1:0]      run_mask_q;

	// timer state
	logic [TW-1:0]      start_q [NT];
	logic [TW-1:0]      per_now_q [NT];
	logic               first_q;

	// per tick working registers
	logic [TW-1:0]      now_q;
	logic [TW-1:0]      diff_q;
	logic [SW-1:0]      cnt_q;
	logic [NT-1:0]      pend_q;
	logic [SW-1:0]      best_q;
	logic               best_vld_q;

	// output register
	logic               out_valid_q;
	logic [SW-1:0]      out_index_q;
	logic               out_fired_q;
	logic               out_last_q;

	logic [TW-1:0]      in_now;
	logic [SW-1:0]      in_slot;
	logic [TW-1:0]      in_newp;

	logic [TW-1:0]      cur_per;
	logic [TW-1:0]      cur_start;
	logic [TW-1:0]      rem;
	logic               due;
	logic               behind;
	logic               cand_wins;
	logic [NT-1:0]      best_sel;
	logic               emit_last;

	assign in_now  = in_data[TW-1:0];
	assign in_slot = in_data[TW+SW-1:TW];
	assign in_newp = in_data[2*TW+SW-1:TW+SW];

	// true when slot a reports before slot b
	function automatic logic goes_before(
		input logic [PW-1:0] pa,
		input logic [PW-1:0] pb,
		input logic [TW-1:0] ca,
		input logic [TW-1:0] cb,
		input logic [SW-1:0] a,
		input logic [SW-1:0] b
	);
		logic r;
		if (pa != pb) begin
			r = pa > pb;
		end else if (ca != cb) begin
			r = ca < cb;
		end else begin
			r = a > b;
		end
		return r;
	endfunction

	assign cur_per   = per_now_q[cnt_q];
	assign cur_start = start_q[cnt_q];
	assign due       = diff_q >= cur_per;
	assign rem       = diff_q - cur_per;
	assign behind    = rem >= cur_per;

	assign cand_wins = pend_q[cnt_q] && (!best_vld_q ||
		goes_before(prio_map_q[cnt_q*PW +: PW], prio_map_q[best_q*PW +: PW],
			period_cfg_q[cnt_q], period_cfg_q[best_q], cnt_q, best_q));

	always_comb begin
		best_sel = '0;
		if (best_vld_q) begin
			best_sel[best_q] = 1'b1;
		end
	end

	assign emit_last = (pend_q & ~best_sel) == '0;

	assign sts.cnt_last  = cnt_q == SW'(NT - 1);
	assign sts.out_free  = !out_valid_q || out_ready;
	assign sts.emit_last = emit_last;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NT; i++) begin
				period_cfg_q[i] <= ptb_pkg::PERIOD_RST;
			end
			prio_map_q <= ptb_pkg::PRIO_MAP_RST;
			run_mask_q <= ptb_pkg::RUN_MASK_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				ptb_pkg::CFG_PERIOD_0: period_cfg_q[0] <= cfg_data;
				ptb_pkg::CFG_PERIOD_1: period_cfg_q[1] <= cfg_data;
				ptb_pkg::CFG_PERIOD_2: period_cfg_q[2] <= cfg_data;
				ptb_pkg::CFG_PERIOD_3: period_cfg_q[3] <= cfg_data;
				ptb_pkg::CFG_PRIO_MAP: prio_map_q <= cfg_data[NT*PW-1:0];
				ptb_pkg::CFG_RUN_MASK: run_mask_q <= cfg_data[NT-1:0];
				default: begin
				end
			endcase
		end
	end

	// timer state: restart on load, per slot update during the walk
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NT; i++) begin
				start_q[i]   <= '0;
				per_now_q[i] <= '0;
			end
			first_q <= 1'b1;
		end else begin
			if (cmd.load && (in_command == ptb_pkg::CMD_RESTART)) begin
				per_now_q[in_slot] <= in_newp;
				start_q[in_slot]   <= in_now;
			end
			if (cmd.upd) begin
				if (first_q) begin
					per_now_q[cnt_q] <= period_cfg_q[cnt_q];
					start_q[cnt_q]   <= now_q;
				end else if (!run_mask_q[cnt_q]) begin
					start_q[cnt_q] <= now_q;
				end else if (due) begin
					start_q[cnt_q] <= behind ? now_q : cur_start + cur_per;
				end
				if (sts.cnt_last) begin
					first_q <= 1'b0;
				end
			end
		end
	end

	// walk counter, pending fire bits and ordering scan
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q      <= '0;
			pend_q     <= '0;
			best_vld_q <= 1'b0;
			best_q     <= '0;
		end else begin
			if (cmd.load || cmd.scan_init) begin
				cnt_q <= '0;
			end else if (cmd.cnt_inc) begin
				cnt_q <= cnt_q + SW'(1);
			end
			if (cmd.load) begin
				pend_q <= '0;
			end else if (cmd.upd) begin
				pend_q[cnt_q] <= first_q || (run_mask_q[cnt_q] && due);
			end else if (cmd.emit) begin
				pend_q <= pend_q & ~best_sel;
			end
			if (cmd.scan_init) begin
				best_vld_q <= 1'b0;
			end else if (cmd.scan_step && cand_wins) begin
				best_vld_q <= 1'b1;
				best_q     <= cnt_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			now_q <= in_now;
		end
		if (cmd.diff) begin
			diff_q <= now_q - cur_start;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_index_q <= best_vld_q ? best_q : '0;
			out_fired_q <= best_vld_q;
			out_last_q  <= emit_last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_index = out_index_q;
	assign out_fired = out_fired_q;
	assign out_last  = out_last_q;

	// a quiet result always closes its tick
	a_quiet_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_fired_q |-> out_last_q) else $error("quiet result not last");

	// a reported slot is not reported again within the same tick
	a_pend_clear: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit && best_vld_q |=> !pend_q[$past(best_q)])
		else $error("reported slot still pending");

	// the first tick happens once
	a_first_once: assert property (@(posedge clk) disable iff (!arst_n)
		!first_q |=> !first_q) else $error("first tick flag set again");

endmodule
